// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

  // fixed point format of every matrix element and quaternion component
  localparam int FRAC_BITS = 30;
  localparam int DATA_W    = 32;

  // internal widths
  localparam int RAD_W   = DATA_W + 3;            // 1 + three signed terms
  localparam int DIFF_W  = DATA_W + 2;            // sum or difference of two elements
  localparam int MAG_W   = DATA_W + 1;            // magnitude of a difference
  localparam int ROOT_W  = DATA_W;                // floor(sqrt(rad * 2^FRAC_BITS))
  localparam int X_W     = 2 * ROOT_W;            // square root operand
  localparam int REM_W   = ROOT_W + 4;            // square root partial remainder
  localparam int DEN_W   = ROOT_W + 1;            // divisor 2*root
  localparam int NUM_W   = MAG_W + FRAC_BITS;     // dividend |d| * 2^FRAC_BITS
  localparam int QBITS   = DATA_W - 1;            // quotient bits below saturation
  localparam int TOP_W   = NUM_W - QBITS;         // dividend bits above the quotient bits

  localparam int SQ_STAGES   = ROOT_W;            // one root bit per stage
  localparam int DIV_STAGES  = QBITS + 1;         // range check plus one bit per stage
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] r00;
    logic signed [DATA_W-1:0] r01;
    logic signed [DATA_W-1:0] r02;
    logic signed [DATA_W-1:0] r10;
    logic signed [DATA_W-1:0] r11;
    logic signed [DATA_W-1:0] r12;
    logic signed [DATA_W-1:0] r20;
    logic signed [DATA_W-1:0] r21;
    logic signed [DATA_W-1:0] r22;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic [1:0]               branch_taken;
    logic                     degenerate;
  } out_t;

  // classification result that travels with an item through the back part
  typedef struct packed {
    logic [1:0]                 br;
    logic                       degen;
    logic [3:0][DIFF_W-1:0]     d;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [X_W-1:0] x;
  } entry_t;

endpackage

// ===== rtl/rmq_front.sv =====
module rmq_front (
  input  rmq_pkg::in_t    in_data,
  output rmq_pkg::entry_t entry
);

  logic signed [rmq_pkg::RAD_W-1:0]  e00, e11, e22, tr, rad;
  logic signed [rmq_pkg::DIFF_W-1:0] e01, e02, e10, e12, e20, e21;
  logic                              pos_tr, x_big, y_big;

  assign e00 = rmq_pkg::RAD_W'(in_data.r00);
  assign e11 = rmq_pkg::RAD_W'(in_data.r11);
  assign e22 = rmq_pkg::RAD_W'(in_data.r22);
  assign e01 = rmq_pkg::DIFF_W'(in_data.r01);
  assign e02 = rmq_pkg::DIFF_W'(in_data.r02);
  assign e10 = rmq_pkg::DIFF_W'(in_data.r10);
  assign e12 = rmq_pkg::DIFF_W'(in_data.r12);
  assign e20 = rmq_pkg::DIFF_W'(in_data.r20);
  assign e21 = rmq_pkg::DIFF_W'(in_data.r21);

  assign tr     = e00 + e11 + e22;
  assign pos_tr = (tr > 0);
  assign x_big  = (in_data.r00 > in_data.r11) && (in_data.r00 > in_data.r22);
  assign y_big  = (in_data.r11 > in_data.r22);

  localparam logic signed [rmq_pkg::RAD_W-1:0] ONE = rmq_pkg::RAD_W'(1) <<< rmq_pkg::FRAC_BITS;

  // branch choice, ties fall to the later branch
  always_comb begin
    entry.side.d = '0;
    priority if (pos_tr) begin
      entry.side.br   = rmq_pkg::BR_TRACE;
      rad             = tr + ONE;
      entry.side.d[1] = e21 - e12;
      entry.side.d[2] = e02 - e20;
      entry.side.d[3] = e10 - e01;
    end else if (x_big) begin
      entry.side.br   = rmq_pkg::BR_X;
      rad             = ONE + e00 - e11 - e22;
      entry.side.d[0] = e21 - e12;
      entry.side.d[2] = e01 + e10;
      entry.side.d[3] = e02 + e20;
    end else if (y_big) begin
      entry.side.br   = rmq_pkg::BR_Y;
      rad             = ONE + e11 - e00 - e22;
      entry.side.d[0] = e02 - e20;
      entry.side.d[1] = e01 + e10;
      entry.side.d[3] = e12 + e21;
    end else begin
      entry.side.br   = rmq_pkg::BR_Z;
      rad             = ONE + e22 - e00 - e11;
      entry.side.d[0] = e10 - e01;
      entry.side.d[1] = e02 + e20;
      entry.side.d[2] = e12 + e21;
    end
    // non-positive radicand flags the item and feeds zero to the root
    entry.side.degen = rad[rmq_pkg::RAD_W-1] || (rad == '0);
    entry.x = entry.side.degen ? '0 :
              {rad[rmq_pkg::X_W-rmq_pkg::FRAC_BITS-1:0], {rmq_pkg::FRAC_BITS{1'b0}}};
  end

endmodule

// ===== rtl/rmq_queue.sv =====
module rmq_queue #(
  parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rmq_pkg::entry_t push_data,
  input  logic            pop,
  output rmq_pkg::entry_t pop_data,
  output logic            empty,
  output logic            full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rmq_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/rmq_sqrt.sv =====
module rmq_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [rmq_pkg::X_W-1:0]     in_x,
  input  rmq_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [rmq_pkg::ROOT_W-1:0]  out_root,
  output rmq_pkg::side_t              out_side
);

  localparam int N = rmq_pkg::SQ_STAGES;

  logic                         valid_r [N];
  logic [rmq_pkg::REM_W-1:0]    rem_r   [N];
  logic [rmq_pkg::ROOT_W-1:0]   root_r  [N];
  logic [rmq_pkg::X_W-1:0]      x_r     [N];
  rmq_pkg::side_t               side_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int I = N - 1 - k;   // operand bit pair handled here
    logic                       v_in;
    logic [rmq_pkg::REM_W-1:0]  rem_in, rem_sh, trial;
    logic [rmq_pkg::ROOT_W-1:0] root_in;
    logic [rmq_pkg::X_W-1:0]    x_in;
    rmq_pkg::side_t             side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = in_x;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = valid_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign rem_sh = {rem_in[rmq_pkg::REM_W-3:0], x_in[2*I+1 -: 2]};
    assign trial  = rmq_pkg::REM_W'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      x_r[k]    <= x_in;
      side_r[k] <= side_in;
      if (rem_sh >= trial) begin
        rem_r[k]  <= rem_sh - trial;
        root_r[k] <= {root_in[rmq_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[k]  <= rem_sh;
        root_r[k] <= {root_in[rmq_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ===== rtl/rmq_div.sv =====
module rmq_div (
  input  logic                               clk,
  input  logic signed [rmq_pkg::DIFF_W-1:0]  in_d,
  input  logic [rmq_pkg::DEN_W-1:0]          in_den,
  output logic signed [rmq_pkg::DATA_W-1:0]  out_q
);

  localparam int N  = rmq_pkg::DIV_STAGES;
  localparam int QB = rmq_pkg::QBITS;

  logic                        neg_r  [N];
  logic                        over_r [N];
  logic [QB-1:0]               nlo_r  [N];
  logic [rmq_pkg::DEN_W-1:0]   rem_r  [N];
  logic [QB-1:0]               q_r    [N];
  logic [rmq_pkg::DEN_W-1:0]   den_r  [N];

  logic                        neg0;
  logic [rmq_pkg::MAG_W-1:0]   mag0;
  logic [rmq_pkg::NUM_W-1:0]   num0;
  logic [rmq_pkg::DEN_W-1:0]   top0;

  assign neg0 = in_d[rmq_pkg::DIFF_W-1];
  assign mag0 = rmq_pkg::MAG_W'(neg0 ? -in_d : in_d);
  assign num0 = {mag0, {rmq_pkg::FRAC_BITS{1'b0}}};
  assign top0 = rmq_pkg::DEN_W'(num0[rmq_pkg::NUM_W-1:QB]);

  // first stage: quotient at or above 2^QB saturates
  always_ff @(posedge clk) begin
    neg_r[0]  <= neg0;
    over_r[0] <= (top0 >= in_den);
    nlo_r[0]  <= num0[QB-1:0];
    rem_r[0]  <= top0;
    q_r[0]    <= '0;
    den_r[0]  <= in_den;
  end

  for (genvar j = 1; j < N; j++) begin : g_stage
    localparam int I = QB - j;   // dividend bit brought down here
    logic [rmq_pkg::DEN_W:0] trial;

    assign trial = {rem_r[j-1], nlo_r[j-1][I]};

    always_ff @(posedge clk) begin
      neg_r[j]  <= neg_r[j-1];
      over_r[j] <= over_r[j-1];
      nlo_r[j]  <= nlo_r[j-1];
      den_r[j]  <= den_r[j-1];
      if (trial >= {1'b0, den_r[j-1]}) begin
        rem_r[j] <= rmq_pkg::DEN_W'(trial - {1'b0, den_r[j-1]});
        q_r[j]   <= {q_r[j-1][QB-2:0], 1'b1};
      end else begin
        rem_r[j] <= rmq_pkg::DEN_W'(trial);
        q_r[j]   <= {q_r[j-1][QB-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (over_r[N-1]) begin
      out_q = neg_r[N-1] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    end else if (neg_r[N-1]) begin
      out_q = -$signed({1'b0, q_r[N-1]});
    end else begin
      out_q = $signed({1'b0, q_r[N-1]});
    end
  end

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// channel   ports                         transfer when
// input     start, busy, in_data          start high and busy low at a rising edge
// result    out_valid, out_data           out_valid high for one cycle, always taken
//
// an accepted matrix leaves as one result after passing the input queue,
// 32 square root stages (one root bit each), 32 divider stages (range check
// plus one quotient bit each) and 1 output register
// one matrix can be accepted every cycle; busy rises only when the input queue is full
// synchronous active-low reset empties the queue and clears all valid bits
// the receiver never stalls, so the back part never holds an item

module rotation_matrix_to_quaternion #(
  parameter int QUEUE_DEPTH = rmq_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rmq_pkg::in_t  in_data,
  output logic          out_valid,
  output rmq_pkg::out_t out_data
);

  localparam int DL = rmq_pkg::DIV_STAGES;

  // front: classify and queue
  rmq_pkg::entry_t front_entry, head;
  logic            q_empty, q_full;

  rmq_front u_front (
    .in_data (in_data),
    .entry   (front_entry)
  );

  rmq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start),
    .push_data (front_entry),
    .pop       (!q_empty),
    .pop_data  (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign busy = q_full;

  // back: square root of the radicand
  logic                        sq_valid;
  logic [rmq_pkg::ROOT_W-1:0]  sq_root;
  rmq_pkg::side_t              sq_side;

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (!q_empty),
    .in_x      (head.x),
    .in_side   (head.side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // divisor 2*root, own component root/2
  logic [rmq_pkg::DEN_W-1:0]   den;
  logic                        degen;

  assign den   = {sq_root, 1'b0};
  assign degen = sq_side.degen || (den == '0);

  // one divider lane per component; the lane of the own component sees zero
  logic signed [rmq_pkg::DATA_W-1:0] lane_q [4];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    rmq_div u_div (
      .clk    (clk),
      .in_d   ($signed(sq_side.d[k])),
      .in_den (den),
      .out_q  (lane_q[k])
    );
  end

  // branch, flag and own component ride alongside the divider lanes
  logic                         dl_valid_r [DL];
  logic [1:0]                   dl_br_r    [DL];
  logic                         dl_degen_r [DL];
  logic [rmq_pkg::ROOT_W-2:0]   dl_own_r   [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) begin
        dl_valid_r[i] <= 1'b0;
      end
    end else begin
      dl_valid_r[0] <= sq_valid;
      for (int i = 1; i < DL; i++) begin
        dl_valid_r[i] <= dl_valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dl_br_r[0]    <= sq_side.br;
    dl_degen_r[0] <= degen;
    dl_own_r[0]   <= sq_root[rmq_pkg::ROOT_W-1:1];
    for (int i = 1; i < DL; i++) begin
      dl_br_r[i]    <= dl_br_r[i-1];
      dl_degen_r[i] <= dl_degen_r[i-1];
      dl_own_r[i]   <= dl_own_r[i-1];
    end
  end

  // result assembly
  logic                               out_valid_r;
  rmq_pkg::out_t                      out_r, out_nxt;
  logic signed [rmq_pkg::DATA_W-1:0]  comp [4];
  logic [1:0]                         fin_br;

  assign fin_br = dl_br_r[DL-1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dl_degen_r[DL-1]) begin
        comp[k] = '0;
      end else if (fin_br == 2'(k)) begin
        comp[k] = $signed({1'b0, dl_own_r[DL-1]});
      end else begin
        comp[k] = lane_q[k];
      end
    end
    out_nxt.quat_w       = comp[0];
    out_nxt.quat_x       = comp[1];
    out_nxt.quat_y       = comp[2];
    out_nxt.quat_z       = comp[3];
    out_nxt.branch_taken = fin_br;
    out_nxt.degenerate   = dl_degen_r[DL-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dl_valid_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // fixed latency from transfer in to result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##66 out_valid)
    else $error("result missing after fixed latency");

  // a degenerate result carries zero components
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.quat_w == '0 && out_data.quat_x == '0 &&
      out_data.quat_y == '0 && out_data.quat_z == '0)
    else $error("degenerate result with nonzero components");

  // the back part never stalls, so the queue never fills
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |=> !busy)
    else $error("input queue filled up");
`endif

endmodule

// ===== bench/tb_rotation_matrix_to_quaternion.sv =====
module tb_rotation_matrix_to_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = longint'(1) << rmq_pkg::FRAC_BITS;
  localparam int LATENCY = 66;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rmq_pkg::in_t in_data = '0;
  logic out_valid;
  rmq_pkg::out_t out_data;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rmq_pkg::in_t matrix_q[$];    // matrices waiting for transfer
  rmq_pkg::out_t quat_q[$];     // predicted quaternions, oldest first
  int errors = 0;
  int idle_pct = 0;    // sender idle chance in percent

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // saturate a wide signed value to 32 bits
  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // floor(sqrt(v)) by bit pairs
  function automatic logic [63:0] int_sqrt(input logic [127:0] v);
    logic [127:0] root, rem, trial;
    root = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  // d * 2^FRAC_BITS / den truncated toward zero, saturated
  function automatic logic [31:0] scaled_div(input longint d, input logic [63:0] den);
    logic signed [127:0] num, q;
    num = 128'(d) <<< rmq_pkg::FRAC_BITS;
    q = num / $signed({64'd0, den});
    return clamp32(q);
  endfunction

  function automatic rmq_pkg::out_t predict_quat(input rmq_pkg::in_t m);
    rmq_pkg::out_t r;
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad;
    longint d[4];
    logic [63:0] root, den;
    logic [31:0] comp[4];
    rmq_pkg::branch_t br;
    a00 = m.r00; a01 = m.r01; a02 = m.r02;
    a10 = m.r10; a11 = m.r11; a12 = m.r12;
    a20 = m.r20; a21 = m.r21; a22 = m.r22;
    tr = a00 + a11 + a22;
    d = '{0, 0, 0, 0};
    if (tr > 0) begin
      br = rmq_pkg::BR_TRACE; rad = tr + ONE;
      d[1] = a21 - a12; d[2] = a02 - a20; d[3] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      br = rmq_pkg::BR_X; rad = ONE + a00 - a11 - a22;
      d[0] = a21 - a12; d[2] = a01 + a10; d[3] = a02 + a20;
    end else if (a11 > a22) begin
      br = rmq_pkg::BR_Y; rad = ONE + a11 - a00 - a22;
      d[0] = a02 - a20; d[1] = a01 + a10; d[3] = a12 + a21;
    end else begin
      br = rmq_pkg::BR_Z; rad = ONE + a22 - a00 - a11;
      d[0] = a10 - a01; d[1] = a02 + a20; d[2] = a12 + a21;
    end
    r = '0;
    r.branch_taken = br;
    if (rad <= 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    root = int_sqrt(128'(rad) << rmq_pkg::FRAC_BITS);
    den = root << 1;
    if (den == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int k = 0; k < 4; k++)
      comp[k] = (k == int'(br)) ? clamp32({64'd0, root >> 1}) : scaled_div(d[k], den);
    r.quat_w = comp[0]; r.quat_x = comp[1]; r.quat_y = comp[2]; r.quat_z = comp[3];
    return r;
  endfunction

  // driver: one nonblocking update of start and in_data per edge, none while start is held against busy
  always @(posedge clk) begin
    if (rst_n) begin
      if (!(start && busy)) begin
        if (matrix_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          in_data <= matrix_q[0];
          quat_q.push_back(predict_quat(matrix_q[0]));
          void'(matrix_q.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed result is taken
  always @(posedge clk) begin
    rmq_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (quat_q.size() == 0) begin
        report("result with nothing pending", 1, 0);
      end else begin
        want = quat_q.pop_front();
        if (out_data.quat_w !== want.quat_w) report("quat_w", out_data.quat_w, want.quat_w);
        if (out_data.quat_x !== want.quat_x) report("quat_x", out_data.quat_x, want.quat_x);
        if (out_data.quat_y !== want.quat_y) report("quat_y", out_data.quat_y, want.quat_y);
        if (out_data.quat_z !== want.quat_z) report("quat_z", out_data.quat_z, want.quat_z);
        if (out_data.branch_taken !== want.branch_taken)
          report("branch_taken", out_data.branch_taken, want.branch_taken);
        if (out_data.degenerate !== want.degenerate)
          report("degenerate", out_data.degenerate, want.degenerate);
      end
    end
  end

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h40000000;           // +1.0
      2: return 32'hc0000000;           // -1.0
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(32'h80000000)) - 32'sh40000000);
    endcase
  endfunction

  // rotation-like matrix in three of four draws: all terms within +-1.0, else rnd_elem values
  function automatic rmq_pkg::in_t rnd_matrix();
    rmq_pkg::in_t m;
    logic [31:0] e[9];
    for (int i = 0; i < 9; i++) e[i] = rnd_elem();
    if ($urandom_range(3) != 0) begin
      for (int i = 0; i < 9; i++)
        e[i] = 32'($signed($urandom_range(32'h80000000)) - 32'sh40000000);
      if ($urandom_range(4) == 0) e[$urandom_range(2) * 4] = 32'h40000000;
    end
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  function automatic rmq_pkg::in_t diag(input logic [31:0] a, b, c, input logic [31:0] off);
    return {a, off, 32'(-off), 32'(-off), b, off, off, 32'(-off), c};
  endfunction

  initial begin
    int phase_pct[4];
    int guard;
    phase_pct = '{0, 60, 0, 16};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: identity, each branch, ties, extremes, degenerate
    matrix_q.push_back(diag(32'h40000000, 32'h40000000, 32'h40000000, 0));
    matrix_q.push_back(diag(32'h40000000, 32'hc0000000, 32'hc0000000, 0));
    matrix_q.push_back(diag(32'hc0000000, 32'h40000000, 32'hc0000000, 0));
    matrix_q.push_back(diag(32'hc0000000, 32'hc0000000, 32'h40000000, 0));
    matrix_q.push_back(diag(0, 0, 0, 32'h10000000));          // trace zero, ties
    matrix_q.push_back(diag(32'hc0000000, 32'hc0000000, 32'hc0000000, 0));
    matrix_q.push_back(diag(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
    matrix_q.push_back(diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    matrix_q.push_back(diag(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    matrix_q.push_back(diag(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000));
    matrix_q.push_back(diag(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    matrix_q.push_back(diag(32'hc0000000, 32'hc0000000, 32'h80000000, 0)); // all negative
    matrix_q.push_back('0);
    matrix_q.push_back('1);
    matrix_q.push_back({9{32'h80000000}});
    matrix_q.push_back({9{32'h7fffffff}});
    matrix_q.push_back(diag(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h55555555));
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      for (int i = 0; i < 283; i++) matrix_q.push_back(rnd_matrix());
      guard = 0;
      while ((matrix_q.size() > 0 || quat_q.size() > 0) && guard < 200000) begin
        @(posedge clk);
        guard++;
      end
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && quat_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // overall limit, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_queue.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
bench/tb_rotation_matrix_to_quaternion.sv
